[sv/tlb_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and beat types for the translation buffer.
// Used by tlb_ctrl, tlb_dpath and the tlb_fifo_lru_table top level.
package tlb_pkg;

  localparam int ENTRIES    = 16;
  localparam int PAGE_BITS  = 20;
  localparam int FRAME_BITS = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_INVAL  = 2'd2;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  localparam logic REG_MODE = 1'b0;

  typedef struct packed {
    logic [1:0]            command;
    logic [PAGE_BITS-1:0]  vpage;
    logic [FRAME_BITS-1:0] frame_number;
  } item_t;

  typedef struct packed {
    logic                  hit;
    logic [FRAME_BITS-1:0] hit_frame;
    logic                  evicted;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic search;
    logic push;
    logic push_from_hit;
    logic remove;
    logic emit;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] command;
    logic       hit;
  } sts_t;

endpackage

[sv/tlb_ctrl.sv]
`timescale 1ns / 1ps
// Controller for the translation buffer: sequences load, search and update.
// Depends on tlb_pkg for the command codes and the control structs.
module tlb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          mode,
  input  tlb_pkg::sts_t sts,
  output tlb_pkg::ctl_t ctl,
  output logic          busy,
  output logic          done
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SEARCH;
            busy  <= 1'b1;
          end
        end
        ST_SEARCH: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE:   ctl.load = start;
      ST_SEARCH: ctl.search = 1'b1;
      ST_UPDATE: begin
        ctl.emit = 1'b1;
        case (sts.command)
          tlb_pkg::CMD_LOOKUP: begin
            ctl.push          = sts.hit && (mode == tlb_pkg::MODE_LRU);
            ctl.push_from_hit = 1'b1;
          end
          tlb_pkg::CMD_INSERT: ctl.push = 1'b1;
          tlb_pkg::CMD_INVAL:  ctl.remove = sts.hit;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

[sv/tlb_dpath.sv]
`timescale 1ns / 1ps
// Datapath for the translation buffer: entry list, parallel match and result.
// Depends on tlb_pkg for sizes, codes and the beat and control structs.
module tlb_dpath (
  input  logic             clk,
  input  logic             rst,
  input  tlb_pkg::ctl_t    ctl,
  input  tlb_pkg::item_t   item,
  output tlb_pkg::sts_t    sts,
  output tlb_pkg::result_t result
);

  logic [1:0]                      cmd_reg;
  logic [tlb_pkg::PAGE_BITS-1:0]   page_reg;
  logic [tlb_pkg::FRAME_BITS-1:0]  frame_reg;
  logic [tlb_pkg::PAGE_BITS-1:0]   pages      [tlb_pkg::ENTRIES];
  logic [tlb_pkg::FRAME_BITS-1:0]  frames     [tlb_pkg::ENTRIES];
  logic [tlb_pkg::PAGE_BITS-1:0]   pages_next [tlb_pkg::ENTRIES];
  logic [tlb_pkg::FRAME_BITS-1:0]  frames_next[tlb_pkg::ENTRIES];
  logic [tlb_pkg::CNT_W-1:0]       count;
  logic [tlb_pkg::CNT_W-1:0]       count_next;
  logic                            hit_reg;
  logic [tlb_pkg::IDX_W-1:0]       pos_reg;

  logic [tlb_pkg::ENTRIES-1:0]     match;
  logic                            any_match;
  logic [tlb_pkg::IDX_W-1:0]       match_pos;
  logic [tlb_pkg::IDX_W-1:0]       push_lim;
  logic [tlb_pkg::PAGE_BITS-1:0]   front_page;
  logic [tlb_pkg::FRAME_BITS-1:0]  front_frame;
  logic                            full;

  assign full = (count == tlb_pkg::CNT_W'(tlb_pkg::ENTRIES));

  // Only entries below the count take part in the match.
  always_comb begin
    for (int i = 0; i < tlb_pkg::ENTRIES; i++) begin
      match[i] = (tlb_pkg::CNT_W'(i) < count) && (pages[i] == page_reg);
    end
  end

  // The entry nearest the front wins.
  always_comb begin
    any_match = |match;
    match_pos = '0;
    for (int i = tlb_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_pos = tlb_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (ctl.push_from_hit) begin
      push_lim    = pos_reg;
      front_page  = pages[pos_reg];
      front_frame = frames[pos_reg];
    end else begin
      push_lim    = tlb_pkg::IDX_W'(tlb_pkg::ENTRIES - 1);
      front_page  = page_reg;
      front_frame = frame_reg;
    end
  end

  // A push shifts entries one place toward the back up to the limit and
  // fills the front; a remove closes the gap at the hit position.
  always_comb begin
    count_next = count;
    for (int i = 0; i < tlb_pkg::ENTRIES; i++) begin
      pages_next[i]  = pages[i];
      frames_next[i] = frames[i];
    end
    if (ctl.push) begin
      for (int i = 1; i < tlb_pkg::ENTRIES; i++) begin
        if (tlb_pkg::IDX_W'(i) <= push_lim) begin
          pages_next[i]  = pages[i-1];
          frames_next[i] = frames[i-1];
        end
      end
      pages_next[0]  = front_page;
      frames_next[0] = front_frame;
      if (!ctl.push_from_hit && !full) begin
        count_next = count + 1'b1;
      end
    end else if (ctl.remove) begin
      for (int i = 0; i < tlb_pkg::ENTRIES - 1; i++) begin
        if (tlb_pkg::IDX_W'(i) >= pos_reg) begin
          pages_next[i]  = pages[i+1];
          frames_next[i] = frames[i+1];
        end
      end
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < tlb_pkg::ENTRIES; i++) begin
      pages[i]  <= pages_next[i];
      frames[i] <= frames_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_reg   <= item.command;
      page_reg  <= item.vpage;
      frame_reg <= item.frame_number;
    end
    if (ctl.search) begin
      hit_reg <= any_match;
      pos_reg <= match_pos;
    end
    if (ctl.emit) begin
      result.hit       <= hit_reg && (cmd_reg == tlb_pkg::CMD_LOOKUP ||
                                      cmd_reg == tlb_pkg::CMD_INVAL);
      result.hit_frame <= (hit_reg && cmd_reg == tlb_pkg::CMD_LOOKUP) ?
                          frames[pos_reg] : '0;
      result.evicted   <= (cmd_reg == tlb_pkg::CMD_INSERT) && full;
    end
  end

  assign sts.command = cmd_reg;
  assign sts.hit     = hit_reg;

endmodule

[sv/tlb_fifo_lru_table.sv]
`timescale 1ns / 1ps
// Fully associative translation buffer with FIFO or LRU ordering.
// A beat is loaded at start, matched in the search state and its result and
// strobe are registered in the update state. A new beat is taken only after
// the load, search, update sequence. The receiver cannot stall the result.
// Synchronous reset empties the table and selects FIFO mode.
module tlb_fifo_lru_table (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  tlb_pkg::item_t   item,
  output logic             busy,
  output logic             result_valid,
  output tlb_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic          mode;
  logic          cfg_write;
  tlb_pkg::ctl_t ctl;
  tlb_pkg::sts_t sts;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= tlb_pkg::MODE_FIFO;
    end else if (cfg_write && paddr[2] == tlb_pkg::REG_MODE) begin
      mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == tlb_pkg::REG_MODE) ? {31'd0, mode} : 32'd0;

  tlb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (result_valid)
  );

  tlb_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .item   (item),
    .sts    (sts),
    .result (result)
  );

endmodule
